>>> design/assoc_lookup_cache_lru_top_assert.svh
// Assertion macros for the associative lookup cache.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef ASSOC_LOOKUP_CACHE_LRU_TOP_ASSERT_SVH
`define ASSOC_LOOKUP_CACHE_LRU_TOP_ASSERT_SVH

// Condition and consequence in the same cycle.
`define ALC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence in the cycle after the condition.
`define ALC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/alc_pkg.sv
// Shared types and constants for the associative lookup cache.
// No dependencies.
`timescale 1ns / 1ps

package alc_pkg;

	// Fixed widths of the ports and of the access stamp.
	localparam int ADDR_BITS  = 64;
	localparam int SLOT_BITS  = 9;
	localparam int STAMP_BITS = 32;

	// Kind of lookup result.
	typedef enum logic [1:0] {
		OUT_FAST    = 2'd0,
		OUT_HIT     = 2'd1,
		OUT_NEW     = 2'd2,
		OUT_REPLACE = 2'd3
	} outcome_t;

endpackage

>>> design/assoc_lookup_cache_lru_top.sv
// Sequence: a hit on the most recent slot goes from idle straight to the result state;
// a lookup that scans the F filled entries (F from 1 to ENTRIES) passes through scan,
// update and result; a lookup into the empty table passes through update and result.
// Each result is then registered at the output. One lookup at a time; the scan reads
// the tag and stamp memories through their single read port, one entry per cycle.
// Reset: asynchronous; empties the table (fill count zero) and clears the stamp counter
// and the recent slot. The memories are not cleared; only filled entries are ever read.
`timescale 1ns / 1ps
`include "assoc_lookup_cache_lru_top_assert.svh"

module assoc_lookup_cache_lru_top #(
	parameter int ENTRIES  = 512,
	parameter int KEY_BITS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [alc_pkg::ADDR_BITS-1:0]    lookup_addr,
	output logic                             out_valid,
	input  logic                             out_stall,
	output alc_pkg::outcome_t                outcome,
	output logic [alc_pkg::SLOT_BITS-1:0]    slot_index
);
	import alc_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_UPDATE = 4'b0100,
		S_RESULT = 4'b1000
	} state_t;

	// Tag and stamp memories, one synchronous read port each.
	logic [KEY_BITS-1:0]   tag_mem   [ENTRIES];
	logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];
	logic [KEY_BITS-1:0]   tag_rd_s1;
	logic [STAMP_BITS-1:0] stamp_rd_s1;

	state_t                state_q;
	logic [CW-1:0]         fill_q;
	logic [STAMP_BITS-1:0] stamp_cnt_q;
	logic [IW-1:0]         recent_slot_q;
	logic                  recent_valid_q;
	logic [KEY_BITS-1:0]   recent_tag_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [CW-1:0]         rd_ptr_q;
	logic                  vld_s1;
	logic                  last_s1;
	logic [IW-1:0]         idx_s1;
	logic [IW-1:0]         oldest_idx_q;
	logic [STAMP_BITS-1:0] oldest_stamp_q;
	logic [IW-1:0]         slot_q;
	outcome_t              kind_q;
	logic                  out_valid_q;
	outcome_t              outcome_q;
	logic [SLOT_BITS-1:0]  slot_index_q;

	logic                  in_xfer;
	logic                  out_free;
	logic [KEY_BITS-1:0]   in_key;
	logic                  fast_hit;
	logic                  match_s1;
	logic                  rd_en;
	logic                  older_s1;
	logic [IW-1:0]         oldest_idx_nxt;
	logic [STAMP_BITS-1:0] oldest_stamp_nxt;
	logic                  table_full;
	logic [STAMP_BITS-1:0] stamp_nxt;
	logic [IW+SLOT_BITS-1:0] slot_wide;

	// Handshake and key decode.
	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_key    = lookup_addr[KEY_BITS-1:0];
	assign fast_hit  = recent_valid_q && (recent_tag_q == in_key);

	// The recent tag register mirrors the memory entry of the recent slot.
	assign match_s1   = vld_s1 && (tag_rd_s1 == key_q);
	assign rd_en      = (state_q == S_SCAN) && (rd_ptr_q != fill_q) && !match_s1;
	assign table_full = (fill_q == CW'(ENTRIES));
	assign stamp_nxt  = stamp_cnt_q + STAMP_BITS'(1);

	// Least stamp so far, keeping the lowest index on a tie.
	assign older_s1         = (idx_s1 == '0) || (oldest_stamp_q > stamp_rd_s1);
	assign oldest_idx_nxt   = older_s1 ? idx_s1 : oldest_idx_q;
	assign oldest_stamp_nxt = older_s1 ? stamp_rd_s1 : oldest_stamp_q;

	assign slot_wide = {{SLOT_BITS{1'b0}}, slot_q};

	// Memory ports: scan reads, update writes; a lookup finishes its writes before
	// the next lookup can start reading, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			tag_rd_s1   <= tag_mem[rd_ptr_q[IW-1:0]];
			stamp_rd_s1 <= stamp_mem[rd_ptr_q[IW-1:0]];
		end
		if (state_q == S_UPDATE) begin
			stamp_mem[slot_q] <= stamp_nxt;
			if (kind_q != OUT_HIT) begin
				tag_mem[slot_q] <= key_q;
			end
		end
	end

	// Payload registers of the lookup in flight.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			key_q <= in_key;
			if (fast_hit) begin
				kind_q <= OUT_FAST;
				slot_q <= recent_slot_q;
			end else begin
				kind_q <= OUT_NEW;
				slot_q <= '0;
			end
		end else if (state_q == S_SCAN && vld_s1) begin
			oldest_idx_q   <= oldest_idx_nxt;
			oldest_stamp_q <= oldest_stamp_nxt;
			if (match_s1) begin
				kind_q <= OUT_HIT;
				slot_q <= idx_s1;
			end else if (last_s1) begin
				kind_q <= table_full ? OUT_REPLACE : OUT_NEW;
				slot_q <= table_full ? oldest_idx_nxt : fill_q[IW-1:0];
			end
		end
		if (rd_en) begin
			idx_s1  <= rd_ptr_q[IW-1:0];
			last_s1 <= ((rd_ptr_q + CW'(1)) == fill_q);
		end
		if (state_q == S_RESULT && out_free) begin
			outcome_q    <= kind_q;
			slot_index_q <= slot_wide[SLOT_BITS-1:0];
		end
		if (state_q == S_UPDATE) begin
			recent_tag_q <= key_q;
		end
	end

	// Sequencer and table bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			fill_q         <= '0;
			stamp_cnt_q    <= '0;
			recent_slot_q  <= '0;
			recent_valid_q <= 1'b0;
			rd_ptr_q       <= '0;
			vld_s1         <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						rd_ptr_q <= '0;
						if (fast_hit) begin
							state_q <= S_RESULT;
						end else if (fill_q == '0) begin
							state_q <= S_UPDATE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						rd_ptr_q <= rd_ptr_q + CW'(1);
					end
					if (match_s1 || (vld_s1 && last_s1)) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					stamp_cnt_q    <= stamp_nxt;
					recent_slot_q  <= slot_q;
					recent_valid_q <= 1'b1;
					if (kind_q == OUT_NEW) begin
						fill_q <= fill_q + CW'(1);
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign outcome    = outcome_q;
	assign slot_index = slot_index_q;

	// Checks on the table bookkeeping.
	`ALC_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= CW'(ENTRIES), "fill count beyond table size")
	`ALC_ASSERT_NOW(a_scan_ptr, state_q == S_SCAN, rd_ptr_q <= fill_q, "scan pointer beyond fill count")
	`ALC_ASSERT_NOW(a_fast_slot, state_q == S_RESULT && kind_q == OUT_FAST, slot_q == recent_slot_q, "fast hit not on recent slot")
	`ALC_ASSERT_NEXT(a_stamp_step, state_q == S_UPDATE, stamp_cnt_q == $past(stamp_cnt_q) + STAMP_BITS'(1), "stamp counter did not advance")
	`ALC_ASSERT_NEXT(a_fill_step, state_q == S_UPDATE && kind_q == OUT_NEW, fill_q == $past(fill_q) + CW'(1), "new entry did not grow the table")

endmodule
